[design/rar_pkg.sv]
// Shared types and constants for the rational arithmetic reduce core.
// No dependencies; imported by every module of the block.
package rar_pkg;

  localparam int unsigned FifoDepthDef = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rar_op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GCD,
    B_DIV,
    B_DONE
  } rar_back_st_e;

  // One classified item: raw pair wrapped to 32 bits plus magnitudes and flags
  typedef struct packed {
    logic [31:0] raw_num;
    logic [31:0] raw_den;
    logic [31:0] mag_num;
    logic [31:0] mag_den;
    logic        neg_num;
    logic        neg_den;
    logic        num_zero;
    logic        den_zero;
  } rar_entry_t;

endpackage

[design/rar_front.sv]
// Front end: accepts fraction pairs, cross-multiplies and classifies.
// Depends on rar_pkg; feeds rar_fifo.
module rar_front
  import rar_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic signed [15:0] num_a_i,
  input  logic signed [15:0] den_a_i,
  input  logic signed [15:0] num_b_i,
  input  logic signed [15:0] den_b_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output rar_entry_t        entry_o
);

  logic              stg_valid_q, stg_valid_d;
  rar_op_e           op_q;
  logic signed [31:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [33:0] rn, rd, rn_n, rd_n, mn, md;
  logic              accept;

  assign in_ready_o = !stg_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = stg_valid_q;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  // Products, one multiplier each, registered before the sum
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= rar_op_e'(req_type_i);
      p0_q <= num_a_i * den_b_i;
      p1_q <= num_b_i * den_a_i;
      p2_q <= num_a_i * num_b_i;
      p3_q <= den_a_i * den_b_i;
    end
  end

  always_comb begin
    case (op_q)
      OP_ADD: begin
        rn = 34'(p0_q) + 34'(p1_q);
        rd = 34'(p3_q);
      end
      OP_SUB: begin
        rn = 34'(p0_q) - 34'(p1_q);
        rd = 34'(p3_q);
      end
      OP_MUL: begin
        rn = 34'(p2_q);
        rd = 34'(p3_q);
      end
      default: begin
        rn = 34'(p0_q);
        rd = 34'(p1_q);
      end
    endcase
    // negate both when both are negative
    if (rn[33] && rd[33]) begin
      rn_n = -rn;
      rd_n = -rd;
    end else begin
      rn_n = rn;
      rd_n = rd;
    end
    mn = rn_n[33] ? -rn_n : rn_n;
    md = rd_n[33] ? -rd_n : rd_n;
    entry_o.raw_num  = rn_n[31:0];
    entry_o.raw_den  = rd_n[31:0];
    entry_o.mag_num  = mn[31:0];
    entry_o.mag_den  = md[31:0];
    entry_o.neg_num  = rn_n[33];
    entry_o.neg_den  = rd_n[33];
    entry_o.num_zero = (rn_n == '0);
    entry_o.den_zero = (rd_n == '0);
  end

endmodule

[design/rar_fifo.sv]
// Short queue of classified items between front and back ends.
// Depends on rar_pkg for the entry type.
module rar_fifo
  import rar_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       push_ready_o,
  input  rar_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output rar_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rar_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[design/rar_back.sv]
// Back end: binary gcd, then two restoring divisions in step, then result hold;
// items with a zero part skip to hold. Depends on rar_pkg; drains rar_fifo.
module rar_back
  import rar_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_o,
  input  rar_entry_t  pop_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] raw_num_o,
  output logic [31:0] raw_den_o,
  output logic [31:0] reduced_num_o,
  output logic [31:0] reduced_den_o,
  output logic        den_is_zero_o
);

  rar_back_st_e st_q, st_d;
  rar_entry_t   ent_q, ent_d;
  logic [31:0]  a_q, a_d, b_q, b_d, g_q, g_d;
  logic [31:0]  qn_q, qn_d, qd_q, qd_d, rn_q, rn_d, rd_q, rd_d;
  logic [4:0]   k_q, k_d, cnt_q, cnt_d;
  logic [32:0]  tn, td, sn, sd;
  logic [31:0]  qnum, qden;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          st_d = (pop_data_i.num_zero || pop_data_i.den_zero) ? B_DONE : B_GCD;
        end
      end
      B_GCD: begin
        if (a_q == '0 || b_q == '0) begin
          st_d = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt_q == 5'd31) begin
          st_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_ready_i) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  assign pop_o = (st_q == B_IDLE) && pop_valid_i;

  // Datapath
  always_comb begin
    ent_d = ent_q;
    a_d   = a_q;
    b_d   = b_q;
    g_d   = g_q;
    k_d   = k_q;
    cnt_d = cnt_q;
    qn_d  = qn_q;
    qd_d  = qd_q;
    rn_d  = rn_q;
    rd_d  = rd_q;
    tn    = {rn_q, qn_q[31]};
    td    = {rd_q, qd_q[31]};
    sn    = tn - {1'b0, g_q};
    sd    = td - {1'b0, g_q};
    case (st_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          ent_d = pop_data_i;
          a_d   = pop_data_i.mag_num;
          b_d   = pop_data_i.mag_den;
          k_d   = '0;
        end
      end
      B_GCD: begin
        if (a_q == '0 || b_q == '0) begin
          g_d   = (a_q | b_q) << k_q;
          qn_d  = ent_q.mag_num;
          qd_d  = ent_q.mag_den;
          rn_d  = '0;
          rd_d  = '0;
          cnt_d = '0;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      B_DIV: begin
        // shift quotient bits into the dividend registers
        if (!sn[32]) begin
          rn_d = sn[31:0];
          qn_d = {qn_q[30:0], 1'b1};
        end else begin
          rn_d = tn[31:0];
          qn_d = {qn_q[30:0], 1'b0};
        end
        if (!sd[32]) begin
          rd_d = sd[31:0];
          qd_d = {qd_q[30:0], 1'b1};
        end else begin
          rd_d = td[31:0];
          qd_d = {qd_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    a_q   <= a_d;
    b_q   <= b_d;
    g_q   <= g_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
    qn_q  <= qn_d;
    qd_q  <= qd_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
  end

  // Outputs
  always_comb begin
    qnum          = ent_q.neg_num ? -qn_q : qn_q;
    qden          = ent_q.neg_den ? -qd_q : qd_q;
    out_valid_o   = (st_q == B_DONE);
    raw_num_o     = ent_q.raw_num;
    raw_den_o     = ent_q.raw_den;
    den_is_zero_o = ent_q.den_zero;
    if (ent_q.num_zero) begin
      reduced_num_o = '0;
      reduced_den_o = 32'd1;
    end else if (ent_q.den_zero) begin
      reduced_num_o = ent_q.raw_num;
      reduced_den_o = ent_q.raw_den;
    end else begin
      reduced_num_o = qnum;
      reduced_den_o = qden;
    end
  end

endmodule

[design/rational_arith_reduce_core.sv]
// Rational add/sub/mul/div with gcd reduction.
// Slave stream: tuser = req_type, tdata = num_a, den_a, num_b, den_b.
// Master stream: tdata = raw_num, raw_den, reduced_num, reduced_den; tuser = den_is_zero.
// The front end accepts an item, registers four 16x16 products and classifies the
// raw pair in the next cycle, then queues it. The back end takes one queued item at
// a time: a binary gcd over the 32-bit magnitudes (one shift or subtract per cycle),
// then restoring division of both magnitudes by the gcd in step. A zero numerator
// or zero denominator skips gcd and division and goes straight to the result hold;
// sustained throughput is set by the back end.
// A finished result is held on the master side until taken; while it waits the
// front end and queue keep taking up to FIFO_DEPTH + 1 further items, after which
// s_axis_tready drops. Reset empties the queue and returns both ends to idle.
// Depends on rar_pkg, rar_front, rar_fifo and rar_back.
module rational_arith_reduce_core
  import rar_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // num_a, den_a, num_b, den_b (16 bits each)
  input  logic [1:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // raw_num, raw_den, reduced_num, reduced_den
  output logic         m_axis_tuser   // den_is_zero
);

  rar_entry_t push_data, pop_data;
  logic push, push_ready, pop_valid, pop;

  rar_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .num_a_i      (s_axis_tdata[15:0]),
    .den_a_i      (s_axis_tdata[31:16]),
    .num_b_i      (s_axis_tdata[47:32]),
    .den_b_i      (s_axis_tdata[63:48]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (push_data)
  );

  rar_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  rar_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .raw_num_o     (m_axis_tdata[31:0]),
    .raw_den_o     (m_axis_tdata[63:32]),
    .reduced_num_o (m_axis_tdata[95:64]),
    .reduced_den_o (m_axis_tdata[127:96]),
    .den_is_zero_o (m_axis_tuser)
  );

  a_zero_den_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:32] == '0)
    else $error("den_is_zero set with nonzero raw denominator");

  a_zero_num_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31:0] == '0 |->
      m_axis_tdata[95:64] == '0 && m_axis_tdata[127:96] == 32'd1)
    else $error("zero numerator not reduced to 0/1");

  a_reduced_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[127:96] != '0)
    else $error("reduced denominator zero");

  a_pop_only_when_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("pop from empty queue");

endmodule

[test/tb_rational_arith_reduce_core.sv]
// Self-checking testbench for rational_arith_reduce_core: fraction pairs in, raw and
// reduced fraction out. Computes every expected fraction itself and compares in order.
// Depends on rar_pkg and the design sources only.
module tb_rational_arith_reduce_core;
  import rar_pkg::*;

  typedef struct packed {
    rar_op_e     op;
    logic [15:0] num_a;
    logic [15:0] den_a;
    logic [15:0] num_b;
    logic [15:0] den_b;
  } frac_req_t;

  typedef struct packed {
    logic [31:0] raw_num;
    logic [31:0] raw_den;
    logic [31:0] red_num;
    logic [31:0] red_den;
    logic        den_zero;
  } frac_res_t;

  localparam int unsigned IdleLimit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_off = 0;
  int unsigned stall_phase = 0;
  bit          stim_done = 1'b0;
  bit          drain_pause = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          failed = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rational_arith_reduce_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // num_a, den_a, num_b, den_b
    .s_axis_tuser  (s_axis_tuser),  // req_type
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // raw_num, raw_den, reduced_num, reduced_den
    .m_axis_tuser  (m_axis_tuser)   // den_is_zero
  );

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Exact 64-bit arithmetic, outputs wrapped to 32 bits
  function automatic frac_res_t reduce_fraction(frac_req_t r);
    frac_res_t   res;
    longint      na, da, nb, db, rn, rd, qn, qd;
    longint unsigned g;
    na = longint'($signed(r.num_a));
    da = longint'($signed(r.den_a));
    nb = longint'($signed(r.num_b));
    db = longint'($signed(r.den_b));
    case (r.op)
      OP_ADD: begin rn = na * db + nb * da; rd = da * db; end
      OP_SUB: begin rn = na * db - nb * da; rd = da * db; end
      OP_MUL: begin rn = na * nb; rd = da * db; end
      default: begin rn = na * db; rd = nb * da; end
    endcase
    if (rn < 0 && rd < 0) begin
      rn = -rn;
      rd = -rd;
    end
    if (rn == 0) begin
      qn = 0;
      qd = 1;
    end else if (rd == 0) begin
      qn = rn;
      qd = rd;
    end else begin
      g = gcd_of(rn < 0 ? -rn : rn, rd < 0 ? -rd : rd);
      qn = rn / longint'(g);
      qd = rd / longint'(g);
    end
    res.raw_num = rn[31:0];
    res.raw_den = rd[31:0];
    res.red_num = qn[31:0];
    res.red_den = qd[31:0];
    res.den_zero = (rd == 0);
    return res;
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 16'(-32767);
      1: return 16'd32767;
      2: return 16'h8000;
      3: return 16'd0;
      4, 5: return 16'($signed($urandom_range(0, 24)) - 12);
      6: return 16'($urandom_range(0, 255) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frac_req_t make_req(rar_op_e op, int na, int da, int nb, int db);
    frac_req_t r;
    r.op = op;
    r.num_a = 16'(na);
    r.den_a = 16'(da);
    r.num_b = 16'(nb);
    r.den_b = 16'(db);
    return r;
  endfunction

  task automatic queue_req(frac_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  initial begin
    frac_req_t r;
    // extremes, each operation, zero numerator and denominator, out-of-range value
    queue_req(make_req(OP_ADD, 1, 2, 1, 3));
    queue_req(make_req(OP_SUB, 1, 2, 1, 2));
    queue_req(make_req(OP_MUL, -3, 4, 2, 9));
    queue_req(make_req(OP_DIV, 3, -4, 9, 2));
    queue_req(make_req(OP_ADD, 32767, 32767, 32767, 32767));
    queue_req(make_req(OP_SUB, -32767, 32767, 32767, -32767));
    queue_req(make_req(OP_MUL, -32767, -32767, -32767, 32767));
    queue_req(make_req(OP_DIV, 32767, -32767, -32767, 1));
    queue_req(make_req(OP_ADD, 5, 0, 3, 7));
    queue_req(make_req(OP_DIV, 5, 3, 0, 7));
    queue_req(make_req(OP_MUL, 0, 0, 3, 0));
    queue_req(make_req(OP_MUL, 0, 5, 3, 7));
    queue_req(make_req(OP_DIV, -32768, -32768, -32768, -32768));
    queue_req(make_req(OP_ADD, -32768, 1, -32768, 1));
    queue_req(make_req(OP_SUB, -1, -1, 1, 1));
    queue_req(make_req(OP_MUL, 7, 11, 13, 17));
    queue_req(make_req(OP_DIV, -21, 6, 14, -9));
    queue_req(make_req(OP_ADD, 16'hffff, 16'haaaa, 16'h5555, 16'h7fff));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 1750; i++) begin
      r.op = rar_op_e'($urandom_range(0, 3));
      r.num_a = rand_field();
      r.den_a = rand_field();
      r.num_b = rand_field();
      r.den_b = rand_field();
      queue_req(r);
      if (i == 900) begin
        // pause the sender until every result is back
        wait (pending_reqs.size() == 1);
        drain_pause = 1'b1;
        wait (expected_fracs.size() == 0 && !s_axis_tvalid);
        drain_pause = 1'b0;
      end
    end
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    stim_done = 1'b1;
    wait (expected_fracs.size() == 0);
    repeat (200) @(posedge clk_i);
    if (failed || mismatches != 0 || expected_fracs.size() != 0) begin
      $display("[FAIL] regression broken");
    end else begin
      $display("[ OK ] regression clean");
    end
    $finish;
  end

  // Sender: bursts of random length with random gaps
  always @(posedge clk_i) begin
    frac_req_t sent;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent = pending_reqs.pop_front();
        expected_fracs = {expected_fracs, reduce_fraction(sent)};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0 && !drain_pause) begin
          // the head of the queue is the next item to offer
          automatic frac_req_t nx = pending_reqs[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nx.den_b, nx.num_b, nx.den_a, nx.num_a};
          s_axis_tuser <= nx.op;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 150);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_off <= 3000;
        m_axis_tready <= 1'b0;
      end else if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_phase[11]) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk_i) begin
    frac_res_t got, exp_r;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[127:96], m_axis_tuser};
        if (expected_fracs.size() == 0) begin
          failed = 1'b1;
          $display("unexpected result transaction %h", got);
        end else begin
          exp_r = expected_fracs.pop_front();
          if (got !== exp_r) begin
            if (mismatches < 10) begin
              $display("mismatch: raw %h/%h red %h/%h dz %b, expected %h/%h %h/%h %b",
                       got.raw_num, got.raw_den, got.red_num, got.red_den, got.den_zero,
                       exp_r.raw_num, exp_r.raw_den, exp_r.red_num, exp_r.red_den,
                       exp_r.den_zero);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule
